@@ rtl/btpl_pkg.sv @@
// ----------------------------------------------------------------------------
// btpl_pkg
// Shared types and constants for the binary trie prefix lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package btpl_pkg;

    // Trie depth and slot width
    localparam int MAX_LEN    = 8;
    localparam int HOP_BITS   = 15;
    localparam int LEN_W      = 4;
    localparam int IDX_W      = MAX_LEN + 1;
    localparam int TABLE_SIZE = (2 << MAX_LEN) - 1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_HOP   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_e;

    typedef enum logic [2:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_WALK,
        SEQ_LAST,
        SEQ_DONE
    } seq_state_e;

    typedef struct packed {
        logic [1:0]          operation;
        logic [MAX_LEN-1:0]  prefix_bits;
        logic [LEN_W-1:0]    prefix_length;
        logic [HOP_BITS-1:0] next_hop;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic                found;
        logic [HOP_BITS-1:0] result_hop;
    } out_item_t;

    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    waddr;
        logic [HOP_BITS-1:0] wdata;
        logic [IDX_W-1:0]    raddr;
    } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/btpl_hop_ram.sv @@
// ----------------------------------------------------------------------------
// btpl_hop_ram
// Next-hop slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btpl_hop_ram
    import btpl_pkg::*;
(
    input  wire logic                aclk,
    input  wire mem_req_t            mem_req,
    output logic [HOP_BITS-1:0]      rdata
);

    logic [HOP_BITS-1:0] mem [TABLE_SIZE];
    logic [HOP_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rdata_reg <= mem[mem_req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/btpl_seq.sv @@
// ----------------------------------------------------------------------------
// btpl_seq
// Trie walk sequencer: clears the store after reset, then descends one level
// per cycle with a shared shift-and-add index unit.
// ----------------------------------------------------------------------------
`default_nettype none

module btpl_seq
    import btpl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire in_item_t            in_item,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output out_item_t                res_item,
    output mem_req_t                 mem_req,
    input  wire logic [HOP_BITS-1:0] rdata
);

    seq_state_e          state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic                walk_seen_reg, walk_seen_next;
    logic [1:0]          op_reg, op_next;
    logic [MAX_LEN-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [HOP_BITS-1:0] hop_reg, hop_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [HOP_BITS-1:0] best_reg, best_next;
    logic                found_reg, found_next;
    out_item_t           res_reg, res_next;

    logic                hit;
    logic [HOP_BITS-1:0] best_upd;
    logic                found_upd;
    logic [LEN_W-1:0]    len_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_CLEAR;
            clr_reg       <= '0;
            walk_seen_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            walk_seen_reg <= walk_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        rem_reg   <= rem_next;
        hop_reg   <= hop_next;
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        res_reg   <= res_next;
    end

    // read data belongs to the level issued in the previous walk cycle
    assign hit       = walk_seen_reg && (rdata != '0);
    assign best_upd  = hit ? rdata : best_reg;
    assign found_upd = found_reg | hit;
    assign len_sat   = (in_item.prefix_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                                 : in_item.prefix_length;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        walk_seen_next = (state_reg == SEQ_WALK);
        op_next        = op_reg;
        key_next       = key_reg;
        rem_next       = rem_reg;
        hop_next       = hop_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_req.we     = 1'b0;
        mem_req.waddr  = idx_reg;
        mem_req.wdata  = '0;
        mem_req.raddr  = idx_reg;

        case (state_reg)
            SEQ_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                clr_next      = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(TABLE_SIZE - 1)) begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next    = in_item.operation;
                    key_next   = in_item.prefix_bits;
                    rem_next   = len_sat;
                    hop_next   = in_item.next_hop;
                    idx_next   = '0;
                    best_next  = '0;
                    found_next = 1'b0;
                    state_next = SEQ_WALK;
                end
            end
            SEQ_WALK: begin
                best_next  = best_upd;
                found_next = found_upd;
                if (rem_reg == '0) begin
                    state_next = SEQ_LAST;
                end else begin
                    // child slot: 2*idx + 1 + next key bit
                    idx_next = {idx_reg[IDX_W-2:0], 1'b0} + IDX_W'(1)
                             + IDX_W'(key_reg[MAX_LEN-1]);
                    key_next = {key_reg[MAX_LEN-2:0], 1'b0};
                    rem_next = rem_reg - LEN_W'(1);
                end
            end
            SEQ_LAST: begin
                res_next = '0;
                case (op_reg)
                    OP_ADD: begin
                        if (hop_reg == '0) begin
                            res_next.status = ST_BAD_HOP;
                        end else begin
                            mem_req.we    = 1'b1;
                            mem_req.wdata = hop_reg;
                        end
                    end
                    OP_DELETE: begin
                        if (rdata == '0) begin
                            res_next.status = ST_NOT_FOUND;
                        end else begin
                            mem_req.we = 1'b1;
                        end
                    end
                    OP_LOOKUP: begin
                        res_next.found      = found_upd;
                        res_next.result_hop = best_upd;
                        res_next.status     = found_upd ? ST_OK : ST_NOT_FOUND;
                    end
                    default: begin
                        res_next.status = ST_OK;
                    end
                endcase
                state_next = SEQ_DONE;
            end
            SEQ_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    assign res_item = res_reg;

    // the store is only written while clearing or finishing an item
    a_no_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_WALK || state_reg == SEQ_IDLE) |-> !mem_req.we)
        else $error("store written during walk or idle");

    a_accept_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == SEQ_WALK))
        else $error("accepted transfer did not start a walk");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_WALK) |-> (rem_reg <= LEN_W'(MAX_LEN)))
        else $error("level count beyond trie depth");

    a_found_has_hop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_DONE && res_reg.found) |-> (res_reg.result_hop != '0))
        else $error("match reported with zero hop");

    a_update_no_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_DONE && op_reg != OP_LOOKUP) |-> !res_reg.found)
        else $error("found set on a non-lookup result");

endmodule

`default_nettype wire

@@ rtl/binary_trie_prefix_lookup_top.sv @@
// Flow: an item of prefix length L (saturated to 8) walks levels 0 to L of the trie,
//   then a finish state writes or answers, and a done state hands the result to the
//   output register. The sequencer takes no new item until the last one is handed
//   off, and walks one level per cycle through the single read port of the slot store.
// Reset: aresetn low clears control state; a clearing pass then zeroes every slot,
//   with s_ready held low until it completes.
// ----------------------------------------------------------------------------
// binary_trie_prefix_lookup_top
// Longest prefix match forwarding table over a complete binary trie of
// next-hop slots, with add, delete and lookup operations.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_prefix_lookup_top
    import btpl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    // Sequencer to store request, and the store's registered read data
    mem_req_t            mem_req;
    logic [HOP_BITS-1:0] rdata;

    // Sequencer result hand-off
    logic                res_valid;
    logic                res_ready;
    out_item_t           res_item;

    // Output register: holds a finished result until the m_ transfer, so the
    // sequencer can take the next s_ transfer while the result waits.
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    btpl_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

    btpl_hop_ram u_ram (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    // Register accepts a new result when empty or when being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ tb/binary_trie_prefix_lookup_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_prefix_lookup_top_tb
// Self-checking bench for the trie forwarding table. Requests are queued up
// front (directed corner cases, then random add/delete/lookup traffic built
// around prefixes already stored) and played through a valid/ready driver.
// A local copy of the slot store predicts each reply as the request is
// transferred, and the monitor checks every reply field against it.
// ----------------------------------------------------------------------------

module binary_trie_prefix_lookup_top_tb;
    import btpl_pkg::*;

    // Spare operation code; the block must answer it without touching the table
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Random request count and settling time after the last reply
    localparam int RANDOM_REQUESTS = 750;
    localparam int DRAIN_CYCLES    = 16;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    binary_trie_prefix_lookup_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction state
    // ------------------------------------------------------------------------

    // Mirror of the trie: one next-hop slot per node, zero meaning empty
    logic [HOP_BITS-1:0] slot_hops [TABLE_SIZE];

    in_item_t  pending_requests [$];   // waiting to be driven
    out_item_t predicted_replies [$];  // awaiting the matching reply transfer
    int        request_total;          // size of the whole request stream
    int        requests_sent = 0;      // input transfers so far
    int        error_count   = 0;

    // Node index of the first len bits of key (len already clipped to MAX_LEN)
    function automatic int node_of(logic [MAX_LEN-1:0] key, int len);
        return ((1 << len) - 1) + int'(key >> (MAX_LEN - len));
    endfunction

    // Applies one request to the mirror and returns the reply it should give
    function automatic out_item_t trie_apply(in_item_t req);
        out_item_t reply;
        int        len;
        int        node;
        reply = '0;
        reply.status = ST_OK;
        len  = (req.prefix_length > MAX_LEN) ? MAX_LEN : int'(req.prefix_length);
        node = node_of(req.prefix_bits, len);
        case (req.operation)
            OP_ADD: begin
                if (req.next_hop == '0)
                    reply.status = ST_BAD_HOP;
                else
                    slot_hops[node] = req.next_hop;
            end
            OP_DELETE: begin
                if (slot_hops[node] == '0)
                    reply.status = ST_NOT_FOUND;
                else
                    slot_hops[node] = '0;
            end
            OP_LOOKUP: begin
                // Deepest occupied node on the key's path wins
                for (int lvl = 0; lvl <= len; lvl++) begin
                    if (slot_hops[node_of(req.prefix_bits, lvl)] != '0) begin
                        reply.result_hop = slot_hops[node_of(req.prefix_bits, lvl)];
                        reply.found      = 1'b1;
                    end
                end
                if (!reply.found)
                    reply.status = ST_NOT_FOUND;
            end
            default: ;  // spare code: plain OK reply, table untouched
        endcase
        return reply;
    endfunction

    task automatic queue_request(logic [1:0] op, logic [MAX_LEN-1:0] bits,
                                 logic [LEN_W-1:0] len, logic [HOP_BITS-1:0] hop);
        in_item_t req;
        req.operation     = op;
        req.prefix_bits   = bits;
        req.prefix_length = len;
        req.next_hop      = hop;
        pending_requests.push_back(req);
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Back-pressure profile: sender idles lightly while the receiver stalls
    // hard, then the reverse, then a final third with no gaps at all
    // ------------------------------------------------------------------------
    function automatic int sender_idle_pct();
        if (requests_sent < request_total / 3)
            return 14;
        if (requests_sent < (2 * request_total) / 3)
            return 74;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (requests_sent < request_total / 3)
            return 74;
        if (requests_sent < (2 * request_total) / 3)
            return 14;
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: predicts on each input transfer, then offers the next request
    // once the channel is free. Valid only drops when nothing is offered.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_replies.push_back(trie_apply(s_data));
                requests_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    s_data  <= pending_requests.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each reply transfer against the oldest prediction and
    // draws a fresh ready for the next cycle
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch($sformatf("reply with nothing outstanding: %h", m_data));
                end else begin
                    want = predicted_replies.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_data.status, want.status));
                    if (m_data.found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b",
                                                  m_data.found, want.found));
                    if (m_data.result_hop !== want.result_hop)
                        report_mismatch($sformatf("result_hop %h, want %h",
                                                  m_data.result_hop, want.result_hop));
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------------
    initial begin
        in_item_t            stored_prefixes [$];
        in_item_t            pick;
        logic [MAX_LEN-1:0]  bits;
        logic [MAX_LEN-1:0]  keep_mask;
        logic [LEN_W-1:0]    len;
        logic [HOP_BITS-1:0] hop;
        int                  roll;
        int                  sel;
        int                  base_len;

        foreach (slot_hops[i])
            slot_hops[i] = '0;

        // Directed: empty table, default route, bad hop, both depth extremes,
        // clipped lengths, ignored key tail, absent delete, spare op code
        queue_request(OP_LOOKUP,  8'h00, 4'd0,  15'h0000);  // nothing stored yet
        queue_request(OP_DELETE,  8'h00, 4'd0,  15'h0000);  // delete of absent route
        queue_request(OP_ADD,     8'h00, 4'd0,  15'h0001);  // default route
        queue_request(OP_ADD,     8'h3C, 4'd5,  15'h0000);  // zero hop refused
        queue_request(OP_LOOKUP,  8'h3C, 4'd5,  15'h7FFF);  // falls back to default
        queue_request(OP_ADD,     8'hFF, 4'd8,  15'h7FFF);  // deepest node, max hop
        queue_request(OP_ADD,     8'hAA, 4'd15, 15'h2AAA);  // length clipped to depth
        queue_request(OP_LOOKUP,  8'hAA, 4'd8,  15'h0000);
        queue_request(OP_LOOKUP,  8'hAB, 4'd12, 15'h0000);
        queue_request(OP_ADD,     8'hA7, 4'd3,  15'h5555);  // tail bits ignored
        queue_request(OP_LOOKUP,  8'hBF, 4'd8,  15'h0000);  // longest match at length 3
        queue_request(OP_LOOKUP,  8'hA0, 4'd2,  15'h0000);  // key shorter than stored prefix
        queue_request(OP_ADD,     8'h80, 4'd1,  15'h4000);
        queue_request(OP_LOOKUP,  8'hFF, 4'd9,  15'h1234);
        queue_request(OP_DELETE,  8'hFF, 4'd8,  15'h0000);
        queue_request(OP_LOOKUP,  8'hFF, 4'd8,  15'h0000);  // now length 1 wins
        queue_request(OP_DELETE,  8'h55, 4'd7,  15'h0000);  // absent
        queue_request(OP_UNUSED,  8'hFF, 4'd15, 15'h7FFF);  // spare code
        queue_request(OP_ADD,     8'hAA, 4'd8,  15'h0FF0);  // overwrite
        queue_request(OP_LOOKUP,  8'hAA, 4'd8,  15'h0000);
        queue_request(OP_DELETE,  8'h00, 4'd0,  15'h0000);  // drop default route
        queue_request(OP_LOOKUP,  8'h00, 4'd0,  15'h0000);  // nothing at root
        queue_request(OP_LOOKUP,  8'h7F, 4'd8,  15'h0000);  // miss on an empty branch

        // Random traffic, mostly built from prefixes already stored so that
        // lookups and deletes hit rather than miss
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            roll = $urandom_range(99);
            bits = 8'($urandom);
            hop  = 15'($urandom_range(32767, 1));
            len  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                            : 4'($urandom_range(8, 0));
            if (roll < 35) begin
                if ($urandom_range(19) == 0)
                    hop = '0;
                queue_request(OP_ADD, bits, len, hop);
                if (hop != '0)
                    stored_prefixes.push_back(pending_requests[$]);
            end else if (roll < 52) begin
                if (stored_prefixes.size() > 0 && $urandom_range(3) != 0) begin
                    sel  = $urandom_range(stored_prefixes.size() - 1);
                    pick = stored_prefixes[sel];
                    stored_prefixes.delete(sel);
                    queue_request(OP_DELETE, pick.prefix_bits, pick.prefix_length, hop);
                end else begin
                    queue_request(OP_DELETE, bits, len, hop);
                end
            end else if (roll < 97) begin
                if (stored_prefixes.size() > 0 && $urandom_range(4) != 0) begin
                    // Key extends a stored prefix with a random tail
                    pick      = stored_prefixes[$urandom_range(stored_prefixes.size() - 1)];
                    base_len  = (pick.prefix_length > MAX_LEN) ? MAX_LEN
                                                               : int'(pick.prefix_length);
                    keep_mask = ~(8'hFF >> base_len);
                    bits      = (pick.prefix_bits & keep_mask) | (bits & ~keep_mask);
                    if ($urandom_range(9) != 0)
                        len = 4'($urandom_range(MAX_LEN, base_len));
                end
                queue_request(OP_LOOKUP, bits, len, hop);
            end else begin
                queue_request(OP_UNUSED, bits, len, hop);
            end
        end
        request_total = pending_requests.size();

        // Synchronous reset, released on a rising edge
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Everything driven, transferred and answered
        do
            @(posedge aclk);
        while (pending_requests.size() > 0 || s_valid || predicted_replies.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("binary_trie_prefix_lookup_top_tb OK");
        else
            $display("binary_trie_prefix_lookup_top_tb NOT OK");
        $finish;
    end

    // Watchdog: fires well past the slowest legal run
    initial begin
        #2_000_000;
        $display("binary_trie_prefix_lookup_top_tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/btpl_pkg.sv
rtl/btpl_hop_ram.sv
rtl/btpl_seq.sv
rtl/binary_trie_prefix_lookup_top.sv
tb/binary_trie_prefix_lookup_top_tb.sv
